@@ rtl/core/pnce_pkg.sv @@
// ----------------------------------------------------------------------------
// pnce_pkg
// Shared types and constants of the periodic neighbor cell enumerator.
// ----------------------------------------------------------------------------
package pnce_pkg;

  localparam int CELL_W        = 18;
  localparam int OFFS_W        = 5;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int RUN_LEN       = 27;
  localparam int DEF_MAX_WIDTH = 64;
  localparam int QUEUE_DEPTH   = 2;

  // divider: quotient bits resolved per cycle
  localparam int DIV_BPS   = 3;
  localparam int DIV_STEPS = CELL_W / DIV_BPS;

  localparam logic [1:0] STEP_DOWN = 2'd0;
  localparam logic [1:0] STEP_STAY = 2'd1;
  localparam logic [1:0] STEP_UP   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_X = 2'd0,
    REG_WIDTH_Y = 2'd1,
    REG_WIDTH_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  // axis selected by the divider
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

@@ rtl/core/pnce_front.sv @@
// ----------------------------------------------------------------------------
// pnce_front
// Accepts a center cell request and splits it into x, y, z coordinates
// with a shared multi-cycle divider, then writes the result into the queue.
// ----------------------------------------------------------------------------
module pnce_front #(
  parameter int COORD_W = pnce_pkg::CFG_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [pnce_pkg::CELL_W-1:0] in_cell_index,
  input  logic [COORD_W-1:0]          width_x,
  input  logic [COORD_W-1:0]          width_y,
  input  logic [COORD_W-1:0]          width_z,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [3*COORD_W:0]          q_data
);

  localparam int STEP_W = $clog2(pnce_pkg::DIV_STEPS);

  pnce_pkg::front_state_t state_r, state_nxt;

  logic [1:0]                  axis_r, axis_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [pnce_pkg::CELL_W-1:0] quo_r, quo_nxt;
  logic [COORD_W-1:0]          rem_r, rem_nxt;
  logic [COORD_W-1:0]          x0_r, x0_nxt;
  logic [COORD_W-1:0]          y0_r, y0_nxt;
  logic [COORD_W-1:0]          z0_r, z0_nxt;
  logic                        single_r, single_nxt;

  logic [COORD_W-1:0]          divisor;
  logic [pnce_pkg::CELL_W-1:0] quo_step;
  logic [COORD_W-1:0]          rem_step;
  logic                        accept;
  logic                        last_step;

  assign accept    = in_push && !in_full;
  assign in_full   = (state_r != pnce_pkg::F_IDLE);
  assign last_step = (step_r == STEP_W'(pnce_pkg::DIV_STEPS - 1));

  always_comb begin
    case (axis_r)
      pnce_pkg::AXIS_X: divisor = width_x;
      pnce_pkg::AXIS_Y: divisor = width_y;
      default:          divisor = width_z;
    endcase
  end

  // restoring division, DIV_BPS bits per cycle
  always_comb begin
    logic [COORD_W:0] ext;
    quo_step = quo_r;
    rem_step = rem_r;
    for (int k = 0; k < pnce_pkg::DIV_BPS; k++) begin
      ext      = {rem_step, quo_step[pnce_pkg::CELL_W-1]};
      quo_step = {quo_step[pnce_pkg::CELL_W-2:0], 1'b0};
      if (ext >= {1'b0, divisor}) begin
        ext         = ext - {1'b0, divisor};
        quo_step[0] = 1'b1;
      end
      rem_step = ext[COORD_W-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    step_nxt   = step_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    x0_nxt     = x0_r;
    y0_nxt     = y0_r;
    z0_nxt     = z0_r;
    single_nxt = single_r;
    q_push     = 1'b0;
    case (state_r)
      pnce_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt  = pnce_pkg::F_DIV;
          axis_nxt   = pnce_pkg::AXIS_X;
          step_nxt   = '0;
          quo_nxt    = in_cell_index;
          rem_nxt    = '0;
          single_nxt = (width_x == COORD_W'(1));
        end
      end
      pnce_pkg::F_DIV: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          step_nxt = '0;
          rem_nxt  = '0;
          case (axis_r)
            pnce_pkg::AXIS_X: begin
              x0_nxt   = rem_step;
              axis_nxt = pnce_pkg::AXIS_Y;
            end
            pnce_pkg::AXIS_Y: begin
              y0_nxt   = rem_step;
              axis_nxt = pnce_pkg::AXIS_Z;
            end
            default: begin
              z0_nxt    = rem_step;
              state_nxt = pnce_pkg::F_PUSH;
            end
          endcase
        end
      end
      pnce_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = pnce_pkg::F_IDLE;
        end
      end
      default: state_nxt = pnce_pkg::F_IDLE;
    endcase
  end

  assign q_data = {single_r, z0_r, y0_r, x0_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pnce_pkg::F_IDLE;
      axis_r  <= pnce_pkg::AXIS_X;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    x0_r     <= x0_nxt;
    y0_r     <= y0_nxt;
    z0_r     <= z0_nxt;
    single_r <= single_nxt;
  end

`ifndef SYNTHESIS
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pnce_pkg::F_DIV) |->
      (axis_r == pnce_pkg::AXIS_X || axis_r == pnce_pkg::AXIS_Y ||
       axis_r == pnce_pkg::AXIS_Z))
    else $error("divider axis out of range");

  a_push_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (axis_r == pnce_pkg::AXIS_Z))
    else $error("queue write before z coordinate resolved");
`endif

endmodule

@@ rtl/core/pnce_queue.sv @@
// ----------------------------------------------------------------------------
// pnce_queue
// Short FIFO of resolved center coordinates between front and back.
// ----------------------------------------------------------------------------
module pnce_queue #(
  parameter int DATA_W = 22,
  parameter int DEPTH  = pnce_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count overflow");
`endif

endmodule

@@ rtl/core/pnce_back.sv @@
// ----------------------------------------------------------------------------
// pnce_back
// Walks the 27 wrapped neighbor offsets of each queued center cell (one for a
// single cell) and forms the linear neighbor index in a three-stage pipeline.
// ----------------------------------------------------------------------------
module pnce_back #(
  parameter int COORD_W = pnce_pkg::CFG_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [COORD_W-1:0]          width_x,
  input  logic [COORD_W-1:0]          width_y,
  input  logic [COORD_W-1:0]          width_z,
  input  logic [2*COORD_W-1:0]        plane,
  input  logic                        q_empty,
  input  logic [3*COORD_W:0]          q_data,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [pnce_pkg::CELL_W-1:0] out_neighbor_cell,
  output logic [pnce_pkg::OFFS_W-1:0] out_offset_number,
  output logic                        out_last
);

  localparam int PW = (3 * COORD_W > pnce_pkg::CELL_W) ? 3 * COORD_W : pnce_pkg::CELL_W;

  function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                    input logic [COORD_W-1:0] w,
                                                    input logic [1:0]         d);
    logic [COORD_W-1:0] r;
    r = c;
    if (d == pnce_pkg::STEP_DOWN) begin
      r = (c == '0) ? w - 1'b1 : c - 1'b1;
    end else if (d == pnce_pkg::STEP_UP) begin
      r = (c == w - 1'b1) ? '0 : c + 1'b1;
    end
    return r;
  endfunction

  // run generator
  logic                        active_r;
  logic                        single_r;
  logic [COORD_W-1:0]          x0_r, y0_r, z0_r;
  logic [1:0]                  dx_r, dy_r, dz_r;
  logic [pnce_pkg::OFFS_W-1:0] n_r;
  logic                        adv;
  logic                        gen_fire;
  logic                        gen_last;
  logic                        load;

  // pipeline
  logic                        s1_v_r;
  logic [COORD_W-1:0]          s1_x_r, s1_y_r, s1_z_r;
  logic [pnce_pkg::OFFS_W-1:0] s1_n_r;
  logic                        s1_last_r;
  logic                        s2_v_r;
  logic [pnce_pkg::CELL_W-1:0] s2_zterm_r, s2_yterm_r;
  logic [COORD_W-1:0]          s2_x_r;
  logic [pnce_pkg::OFFS_W-1:0] s2_n_r;
  logic                        s2_last_r;
  logic                        out_v_r;
  logic [pnce_pkg::CELL_W-1:0] out_cell_r;
  logic [pnce_pkg::OFFS_W-1:0] out_n_r;
  logic                        out_last_r;

  logic [PW-1:0]               zprod, yprod;

  assign adv      = !out_v_r || out_pop;
  assign gen_fire = active_r && adv;
  assign gen_last = single_r || (n_r == pnce_pkg::OFFS_W'(pnce_pkg::RUN_LEN - 1));
  assign load     = adv && (!active_r || gen_last) && !q_empty;
  assign q_pop    = load;

  assign zprod = PW'(s1_z_r) * PW'(plane);
  assign yprod = PW'(s1_y_r) * PW'(width_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (adv) begin
      active_r <= load || (active_r && !gen_last);
      s1_v_r   <= active_r;
      s2_v_r   <= s1_v_r;
      out_v_r  <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      {single_r, z0_r, y0_r, x0_r} <= q_data;
      dx_r <= pnce_pkg::STEP_DOWN;
      dy_r <= pnce_pkg::STEP_DOWN;
      dz_r <= pnce_pkg::STEP_DOWN;
      n_r  <= '0;
    end else if (gen_fire) begin
      n_r <= n_r + 1'b1;
      if (dx_r == pnce_pkg::STEP_UP) begin
        dx_r <= pnce_pkg::STEP_DOWN;
        if (dy_r == pnce_pkg::STEP_UP) begin
          dy_r <= pnce_pkg::STEP_DOWN;
          dz_r <= dz_r + 1'b1;
        end else begin
          dy_r <= dy_r + 1'b1;
        end
      end else begin
        dx_r <= dx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (single_r) begin
        s1_x_r <= '0;
        s1_y_r <= '0;
        s1_z_r <= '0;
      end else begin
        s1_x_r <= wrap_coord(x0_r, width_x, dx_r);
        s1_y_r <= wrap_coord(y0_r, width_y, dy_r);
        s1_z_r <= wrap_coord(z0_r, width_z, dz_r);
      end
      s1_n_r     <= n_r;
      s1_last_r  <= gen_last;
      s2_zterm_r <= zprod[pnce_pkg::CELL_W-1:0];
      s2_yterm_r <= yprod[pnce_pkg::CELL_W-1:0];
      s2_x_r     <= s1_x_r;
      s2_n_r     <= s1_n_r;
      s2_last_r  <= s1_last_r;
      out_cell_r <= s2_zterm_r + s2_yterm_r + pnce_pkg::CELL_W'(s2_x_r);
      out_n_r    <= s2_n_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_empty         = !out_v_r;
  assign out_neighbor_cell = out_cell_r;
  assign out_offset_number = out_n_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_last_r) |->
      (out_n_r < pnce_pkg::OFFS_W'(pnce_pkg::RUN_LEN - 1)))
    else $error("offset past end of run without last");

  a_last_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_last_r) |->
      (out_n_r == pnce_pkg::OFFS_W'(pnce_pkg::RUN_LEN - 1) || out_n_r == '0))
    else $error("last flag on wrong offset");
`endif

endmodule

@@ rtl/core/periodic_neighbor_cell_enumerator_core.sv @@
// ----------------------------------------------------------------------------
// periodic_neighbor_cell_enumerator_core
// Enumerates the 27 periodic neighbor cells of a center cell of a 3-D grid.
// ----------------------------------------------------------------------------
// Each center cell request yields 27 results (dz outer, dy, dx fastest, each
// -1..+1), or a single result of cell 0 when width_x is 1; out_last marks the
// end of a run. The front resolves the request into coordinates (accept,
// divider steps at 3 quotient bits per cycle for x, y then z, queue write);
// the back then emits one result per cycle while out_pop keeps its output
// drained, through its s1, s2 and output registers. A two-entry queue between
// them lets the next request be split while the current run is streaming, so
// the sustained request rate is set by the back's one-result-per-cycle output;
// single-cell runs are bound by the front's divider instead. Widths of 0 act as
// 1 and widths above MAX_WIDTH act as MAX_WIDTH; write configuration only
// while no run is pending.
module periodic_neighbor_cell_enumerator_core #(
  parameter int MAX_WIDTH = pnce_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pnce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pnce_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [pnce_pkg::CELL_W-1:0]    in_cell_index,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [pnce_pkg::CELL_W-1:0]    out_neighbor_cell,
  output logic [pnce_pkg::OFFS_W-1:0]    out_offset_number,
  output logic                           out_last
);

  localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
  localparam int COORD_W = (MW_BITS < pnce_pkg::CFG_W) ? MW_BITS : pnce_pkg::CFG_W;
  localparam int ENTRY_W = 3 * COORD_W + 1;

  function automatic logic [COORD_W-1:0] clamp_width(input logic [pnce_pkg::CFG_W-1:0] raw);
    logic [COORD_W-1:0] r;
    if (raw == '0) begin
      r = COORD_W'(1);
    end else if (int'(raw) > MAX_WIDTH) begin
      r = COORD_W'(MAX_WIDTH);
    end else begin
      r = COORD_W'(raw);
    end
    return r;
  endfunction

  logic [COORD_W-1:0]   width_x_r, width_y_r, width_z_r;
  logic [2*COORD_W-1:0] plane_r;
  logic                 q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0]   q_wr_data, q_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_x_r <= COORD_W'(1);
      width_y_r <= COORD_W'(1);
      width_z_r <= COORD_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        pnce_pkg::REG_WIDTH_X: width_x_r <= clamp_width(cfg_data);
        pnce_pkg::REG_WIDTH_Y: width_y_r <= clamp_width(cfg_data);
        pnce_pkg::REG_WIDTH_Z: width_z_r <= clamp_width(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    plane_r <= (2*COORD_W)'(width_x_r) * (2*COORD_W)'(width_y_r);
  end

  pnce_front #(
    .COORD_W (COORD_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cell_index (in_cell_index),
    .width_x       (width_x_r),
    .width_y       (width_y_r),
    .width_z       (width_z_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wr_data)
  );

  pnce_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (pnce_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  pnce_back #(
    .COORD_W (COORD_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .width_x           (width_x_r),
    .width_y           (width_y_r),
    .width_z           (width_z_r),
    .plane             (plane_r),
    .q_empty           (q_empty),
    .q_data            (q_rd_data),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_neighbor_cell (out_neighbor_cell),
    .out_offset_number (out_offset_number),
    .out_last          (out_last)
  );

endmodule
